// ===== src/srfp_pkg.sv =====
// Package with the shared types, codes and constants of the serial response frame parser.
package srfp_pkg;

    // Sync characters and payload limit
    localparam logic [7:0] SYNC_FIRST      = 8'h7A;
    localparam logic [7:0] SYNC_SECOND     = 8'h62;
    localparam logic [7:0] MAX_FRAME_BYTES = 8'd127;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ID  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [7:0] ENERGY_ID_RST = 8'd0;
    localparam logic [7:0] BLOCK_ID_RST  = 8'd1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ENERGY  = 2'd1,
        KIND_STATUS  = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_SYNC1 = 4'b0001,
        PH_SYNC2 = 4'b0010,
        PH_ID    = 4'b0100,
        PH_BODY  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] energy_id;
        logic [7:0] block_id;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] level;
        logic [7:0] response_id;
        logic [7:0] frame_length;
        logic       last;
        logic       oversize;
    } t_result;

endpackage

// ===== src/srfp_if.sv =====
// Interfaces of the byte request channel and the result request channel.
interface srfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface srfp_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] level;
    logic [7:0] response_id;
    logic [7:0] frame_length;
    logic       last;
    logic       oversize;

    modport source (
        output valid, output kind, output value, output level, output response_id,
        output frame_length, output last, output oversize, input ready
    );
    modport sink (
        input valid, input kind, input value, input level, input response_id,
        input frame_length, input last, input oversize, output ready
    );
endinterface

// ===== src/srfp_cfg_regs.sv =====
// Configuration registers holding the energy and receive-block response ids.
module srfp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    output srfp_pkg::t_cfg                 o_cfg
);

    logic [7:0] r_energy_id;
    logic [7:0] r_block_id;

    // Write the addressed id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_id <= srfp_pkg::ENERGY_ID_RST;
            r_block_id  <= srfp_pkg::BLOCK_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srfp_pkg::CFG_ENERGY_ID: r_energy_id <= i_cfg_data;
                srfp_pkg::CFG_BLOCK_ID:  r_block_id  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.energy_id = r_energy_id;
    assign o_cfg.block_id  = r_block_id;

endmodule

// ===== src/srfp_parser.sv =====
// Frame parser state and the per-byte decode that yields at most one result.
module srfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  srfp_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output srfp_pkg::t_result o_res
);

    srfp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_cur_id, n_cur_id;
    logic       r_status_seen, n_status_seen;
    logic [7:0] r_status, n_status;
    logic       r_level_seen, n_level_seen;
    logic [7:0] r_level, n_level;
    logic       r_len_seen, n_len_seen;
    logic [7:0] r_len, n_len;
    logic [7:0] r_count, n_count;

    // Decode one byte against the current phase
    always_comb begin
        n_phase       = r_phase;
        n_cur_id      = r_cur_id;
        n_status_seen = r_status_seen;
        n_status      = r_status;
        n_level_seen  = r_level_seen;
        n_level       = r_level;
        n_len_seen    = r_len_seen;
        n_len         = r_len;
        n_count       = r_count;
        o_res_valid   = 1'b0;
        o_res         = '0;
        if (i_step) begin
            unique case (r_phase)
                srfp_pkg::PH_SYNC1: begin
                    if (i_byte == srfp_pkg::SYNC_FIRST) begin
                        n_phase = srfp_pkg::PH_SYNC2;
                    end else begin
                        n_phase = srfp_pkg::PH_SYNC1;
                        if (i_byte != 8'd0) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = srfp_pkg::KIND_ERROR;
                            o_res.value = i_byte;
                        end
                    end
                end
                srfp_pkg::PH_SYNC2: begin
                    if (i_byte == srfp_pkg::SYNC_SECOND) begin
                        n_status_seen = 1'b0;
                        n_level_seen  = 1'b0;
                        n_len_seen    = 1'b0;
                        n_count       = 8'd0;
                        n_phase       = srfp_pkg::PH_ID;
                    end else begin
                        n_phase = srfp_pkg::PH_SYNC1;
                        if (i_byte != 8'd0) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = srfp_pkg::KIND_ERROR;
                            o_res.value = i_byte;
                        end
                    end
                end
                srfp_pkg::PH_ID: begin
                    n_cur_id = i_byte;
                    n_phase  = srfp_pkg::PH_BODY;
                end
                srfp_pkg::PH_BODY: begin
                    // Energy id wins when both registers match
                    priority if (r_cur_id == i_cfg.energy_id) begin
                        if (!r_status_seen) begin
                            n_status      = i_byte;
                            n_status_seen = 1'b1;
                        end else begin
                            n_level           = i_byte;
                            n_level_seen      = 1'b1;
                            n_phase           = srfp_pkg::PH_SYNC1;
                            o_res_valid       = 1'b1;
                            o_res.kind        = srfp_pkg::KIND_ENERGY;
                            o_res.value       = r_status;
                            o_res.level       = i_byte;
                            o_res.response_id = r_cur_id;
                        end
                    end else if (r_cur_id == i_cfg.block_id) begin
                        if (!r_level_seen) begin
                            n_level      = i_byte;
                            n_level_seen = 1'b1;
                        end else if (!r_len_seen) begin
                            n_len      = i_byte;
                            n_len_seen = 1'b1;
                            n_count    = 8'd0;
                        end else begin
                            // Stream payload, finish once the count reaches the length
                            n_count            = r_count + 8'd1;
                            o_res_valid        = 1'b1;
                            o_res.kind         = srfp_pkg::KIND_PAYLOAD;
                            o_res.value        = i_byte;
                            o_res.level        = r_level;
                            o_res.response_id  = r_cur_id;
                            o_res.frame_length = r_len;
                            o_res.last         = (n_count >= r_len);
                            o_res.oversize     = (r_len > srfp_pkg::MAX_FRAME_BYTES);
                            if (n_count >= r_len) begin
                                n_phase = srfp_pkg::PH_SYNC1;
                            end
                        end
                    end else begin
                        if (!r_status_seen) begin
                            n_status      = i_byte;
                            n_status_seen = 1'b1;
                        end
                        n_phase           = srfp_pkg::PH_SYNC1;
                        o_res_valid       = 1'b1;
                        o_res.kind        = srfp_pkg::KIND_STATUS;
                        o_res.value       = r_status_seen ? r_status : i_byte;
                        o_res.response_id = r_cur_id;
                    end
                end
                default: begin
                    n_phase = srfp_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= srfp_pkg::PH_SYNC1;
            r_cur_id      <= 8'd0;
            r_status_seen <= 1'b0;
            r_status      <= 8'd0;
            r_level_seen  <= 1'b0;
            r_level       <= 8'd0;
            r_len_seen    <= 1'b0;
            r_len         <= 8'd0;
            r_count       <= 8'd0;
        end else begin
            r_phase       <= n_phase;
            r_cur_id      <= n_cur_id;
            r_status_seen <= n_status_seen;
            r_status      <= n_status;
            r_level_seen  <= n_level_seen;
            r_level       <= n_level;
            r_len_seen    <= n_len_seen;
            r_len         <= n_len;
            r_count       <= n_count;
        end
    end

endmodule

// ===== src/serial_response_frame_parser.sv =====
// Top level of the serial response frame parser: input register, parser and result register.
//
// Usage:
//   i_rx carries one received serial byte per request (valid/ready). The block
//   hunts for the sync pair 'z','b', takes a response id and decodes the body.
//   o_res carries at most one result per byte: a payload byte, an energy
//   report, a command status or a framing error, with the id, level, frame
//   length, last and oversize fields.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the energy id (index 0) and the
//   receive-block id (index 1); write them only while the block is idle.
// Timing:
//   A byte accepted into the input register is decoded from there and its
//   result, if any, is loaded into the result register and driven on o_res.
//   One byte per cycle is sustained while o_res.ready is high, set by the
//   single decode step between the input register and the result register.
// Reset and stall:
//   Synchronous reset clears the parser to the hunt for 'z', drops any
//   pending byte and result, and loads ids 0 and 1. While the receiver holds
//   o_res.ready low the result is held, one more byte is kept in the input
//   register, and i_rx.ready drops until the result is taken.
module serial_response_frame_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    srfp_rx_if.sink                        i_rx,
    srfp_res_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [srfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    srfp_pkg::t_result r_out;
    logic              advance;
    logic              res_valid;
    srfp_pkg::t_result res;
    srfp_pkg::t_cfg    cfg;

    // Decode the held byte when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || advance;

    srfp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    srfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Capture an incoming byte request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Load a new result or drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.value        = r_out.value;
    assign o_res.level        = r_out.level;
    assign o_res.response_id  = r_out.response_id;
    assign o_res.frame_length = r_out.frame_length;
    assign o_res.last         = r_out.last;
    assign o_res.oversize     = r_out.oversize;

`ifndef SYNTHESIS
    // No decode while a result is stalled
    a_no_advance_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !advance)
        else $error("decode advanced over a stalled result");

    // A result appears only from a pending byte
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((!r_out_valid || o_res.ready) && !r_in_valid) |=> !r_out_valid)
        else $error("result appeared without a pending byte");

    // Last marks payload results only
    a_last_on_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last) |-> (r_out.kind == srfp_pkg::KIND_PAYLOAD))
        else $error("last set on a non-payload result");

    // Framing errors carry no frame context
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == srfp_pkg::KIND_ERROR) |->
        (r_out.level == 8'd0 && r_out.response_id == 8'd0 && r_out.frame_length == 8'd0))
        else $error("framing error carries frame fields");
`endif

endmodule
